// ===== rtl/byte_ring_fifo_with_skip_top_macros.svh =====
// Assertion macros for the byte ring FIFO.
// Included by the top level; depends on nothing else.
`ifndef BYTE_RING_FIFO_WITH_SKIP_TOP_MACROS_SVH
`define BYTE_RING_FIFO_WITH_SKIP_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BRF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("byte ring FIFO check failed");

// Next-cycle implication, checked outside reset.
`define BRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("byte ring FIFO check failed");

`endif

// ===== rtl/brf_pkg.sv =====
// Package for the byte ring FIFO: request codes, field widths, result record.
// Depends on nothing; imported by byte_ring_fifo_with_skip_top.
`timescale 1ns / 1ps

package brf_pkg;

  // Built depth of the ring and the capacity after reset.
  localparam int unsigned DEPTH_DEFAULT = 4096;
  localparam int unsigned CAP_W         = 13;
  localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

  // Field widths of the channels.
  localparam int unsigned REQ_W  = 3;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = 13;
  localparam int unsigned TOT_W  = 64;

  // Configuration port: byte address width, data width, register index.
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;
  localparam logic REG_CAPACITY  = 1'b0;

  // Request codes carried by in_req_type.
  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE    = 3'd0,
    REQ_READ     = 3'd1,
    REQ_SKIP     = 3'd2,
    REQ_FLUSH    = 3'd3,
    REQ_MARK_END = 3'd4
  } req_t;

  // Result of one item while it waits for the memory read data.
  typedef struct packed {
    logic             is_read;
    logic [CNT_W-1:0] moved;
    logic [CNT_W-1:0] fill_level;
    logic             at_end;
    logic [TOT_W-1:0] total_written;
    logic [TOT_W-1:0] total_read;
  } res_t;

endpackage

// ===== rtl/byte_ring_fifo_with_skip_top.sv =====
// Byte ring FIFO with skip, flush and end mark: single-module top level.
// Depends on brf_pkg and byte_ring_fifo_with_skip_top_macros.svh.
`timescale 1ns / 1ps
//
// Usage:
// - The in_ channel carries one request per beat: write a byte, read the
//   oldest byte, skip up to in_count bytes, flush, or mark the end of data.
// - Every request yields exactly one result beat on the out_ channel with the
//   byte read, the bytes moved, the fill level, end-of-data and both 64-bit
//   running totals.
// - The ring storage is one synchronous memory with one write and one read
//   port. Pointers, fill level and totals sit in registers and are updated at
//   the beat's acceptance, so one request per clock is taken unless out_ stalls.
// - Each result is held first in the staged result register, beside the memory
//   read data, and then in the output register.
// - When the receiver stalls, the staged result and the output register fill
//   up and in_ready drops; nothing is lost.
// - The capacity register (address 0) may be written only while idle; the
//   write also empties the ring but keeps the totals.
// - Reset empties the ring, clears the totals and sets capacity to 4096 (or
//   the built depth if smaller). The memory is not cleared; it needs no pass.
//
module byte_ring_fifo_with_skip_top #(
  parameter int unsigned DEPTH = brf_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Request channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [brf_pkg::REQ_W-1:0]  in_req_type,
  input  logic [brf_pkg::BYTE_W-1:0] in_data_byte,
  input  logic [brf_pkg::CNT_W-1:0]  in_count,
  // Result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [brf_pkg::BYTE_W-1:0] out_read_byte,
  output logic [brf_pkg::CNT_W-1:0]  out_moved,
  output logic [brf_pkg::CNT_W-1:0]  out_fill_level,
  output logic                       out_at_end,
  output logic [brf_pkg::TOT_W-1:0]  out_total_written,
  output logic [brf_pkg::TOT_W-1:0]  out_total_read,
  // Configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [brf_pkg::CFG_AW-1:0] paddr,
  input  logic [brf_pkg::CFG_DW-1:0] pwdata,
  output logic [brf_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import brf_pkg::*;

`include "byte_ring_fifo_with_skip_top_macros.svh"

  // Index width and count width (counts reach DEPTH itself).
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PW = AW + 1;
  localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);
  localparam logic [PW-1:0] CAP_RESET_EFF =
    (int'(CAP_RESET) > int'(DEPTH)) ? PW'(DEPTH) : PW'(CAP_RESET);

  // Control and pointer state
  logic [CAP_W-1:0] cap_r;
  logic [PW-1:0]    eff_cap_r;
  logic [AW-1:0]    ridx_r, ridx_nxt;
  logic [AW-1:0]    widx_r, widx_nxt;
  logic [PW-1:0]    held_r, held_nxt;
  logic             end_mark_r, end_mark_nxt;
  logic [TOT_W-1:0] wtot_r, wtot_nxt;
  logic [TOT_W-1:0] rtot_r, rtot_nxt;

  // Pipeline: staged result, memory read data, output register
  logic              s1_valid_r;
  res_t              s1_r, s1_nxt;
  logic [BYTE_W-1:0] mem_q_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  res_t              out_r;

  logic [BYTE_W-1:0] mem [DEPTH];

  logic             in_fire;
  logic             s1_move;
  logic             cfg_wr;
  logic             mem_we;
  logic             mem_re;
  logic [PW-1:0]    moved;
  logic [PW:0]      skip_sum;
  logic [PW-1:0]    widx_inc;
  logic [PW-1:0]    ridx_inc;
  logic [CAP_W-1:0] cap_wr;
  logic [PW-1:0]    eff_cap_wr;
  req_t             req;

  // Handshakes
  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_move;
  assign in_fire  = in_valid && in_ready;
  assign req      = req_t'(in_req_type);

  // Configuration decode and clamping of the written capacity.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[CFG_AW-1:2] == REG_CAPACITY);
  assign cap_wr = pwdata[CAP_W-1:0];
  always_comb begin
    if (cap_wr == '0) begin
      eff_cap_wr = PW'(1);
    end else if (32'(cap_wr) > 32'(DEPTH)) begin
      eff_cap_wr = DEPTH_P;
    end else begin
      eff_cap_wr = PW'(cap_wr);
    end
  end
  assign prdata = (paddr[CFG_AW-1:2] == REG_CAPACITY) ? CFG_DW'(cap_r) : '0;

  // Ring arithmetic: indices stay below the capacity, so one compare wraps.
  assign widx_inc = PW'(widx_r) + PW'(1);
  assign ridx_inc = PW'(ridx_r) + PW'(1);
  assign moved    = (32'(in_count) < 32'(held_r)) ? PW'(in_count) : held_r;
  assign skip_sum = (PW+1)'(ridx_r) + (PW+1)'(moved);

  // Next state and staged result of the accepted request.
  always_comb begin
    ridx_nxt     = ridx_r;
    widx_nxt     = widx_r;
    held_nxt     = held_r;
    end_mark_nxt = end_mark_r;
    wtot_nxt     = wtot_r;
    rtot_nxt     = rtot_r;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    s1_nxt       = '0;
    case (req)
      REQ_WRITE: begin
        if (held_r < eff_cap_r) begin
          mem_we       = 1'b1;
          widx_nxt     = (widx_inc == eff_cap_r) ? '0 : widx_inc[AW-1:0];
          held_nxt     = held_r + PW'(1);
          wtot_nxt     = wtot_r + TOT_W'(1);
          s1_nxt.moved = CNT_W'(1);
        end
      end
      REQ_READ: begin
        if (held_r != '0) begin
          mem_re         = 1'b1;
          s1_nxt.is_read = 1'b1;
          ridx_nxt       = (ridx_inc == eff_cap_r) ? '0 : ridx_inc[AW-1:0];
          held_nxt       = held_r - PW'(1);
          rtot_nxt       = rtot_r + TOT_W'(1);
          s1_nxt.moved   = CNT_W'(1);
        end
      end
      REQ_SKIP: begin
        ridx_nxt = (skip_sum >= (PW+1)'(eff_cap_r))
                   ? AW'(skip_sum - (PW+1)'(eff_cap_r)) : AW'(skip_sum);
        held_nxt     = held_r - moved;
        s1_nxt.moved = CNT_W'(moved);
      end
      REQ_FLUSH: begin
        ridx_nxt     = '0;
        widx_nxt     = '0;
        held_nxt     = '0;
        end_mark_nxt = 1'b0;
      end
      REQ_MARK_END: begin
        end_mark_nxt = 1'b1;
      end
      default: begin
        // Unused codes leave the state alone and report it.
      end
    endcase
    s1_nxt.fill_level    = CNT_W'(held_nxt);
    s1_nxt.at_end        = end_mark_nxt && (held_nxt == '0);
    s1_nxt.total_written = wtot_nxt;
    s1_nxt.total_read    = rtot_nxt;
  end

  // Pointer, fill and total registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r      <= CAP_RESET;
      eff_cap_r  <= CAP_RESET_EFF;
      ridx_r     <= '0;
      widx_r     <= '0;
      held_r     <= '0;
      end_mark_r <= 1'b0;
      wtot_r     <= '0;
      rtot_r     <= '0;
    end else if (cfg_wr) begin
      cap_r      <= cap_wr;
      eff_cap_r  <= eff_cap_wr;
      ridx_r     <= '0;
      widx_r     <= '0;
      held_r     <= '0;
      end_mark_r <= 1'b0;
    end else if (in_fire) begin
      ridx_r     <= ridx_nxt;
      widx_r     <= widx_nxt;
      held_r     <= held_nxt;
      end_mark_r <= end_mark_nxt;
      wtot_r     <= wtot_nxt;
      rtot_r     <= rtot_nxt;
    end
  end

  // Ring memory: one write port, one registered read port. A read never
  // shares a cycle with a write, and a byte written is readable next cycle.
  always_ff @(posedge clk) begin
    if (in_fire && mem_we) begin
      mem[widx_r] <= in_data_byte;
    end
    if (in_fire && mem_re) begin
      mem_q_r <= mem[ridx_r];
    end
  end

  // Staged result waiting for the memory read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_r      <= s1_r;
      out_byte_r <= s1_r.is_read ? mem_q_r : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_byte     = out_byte_r;
  assign out_moved         = out_r.moved;
  assign out_fill_level    = out_r.fill_level;
  assign out_at_end        = out_r.at_end;
  assign out_total_written = out_r.total_written;
  assign out_total_read    = out_r.total_read;

  // Checks: the fill level never exceeds the capacity, the indices stay
  // inside the ring, and read data holds while its result is stalled.
  `BRF_ASSERT_IMPLY(a_held_le_cap, clk, rst_n, 1'b1, held_r <= eff_cap_r)
  `BRF_ASSERT_IMPLY(a_idx_in_ring, clk, rst_n, 1'b1, (PW'(ridx_r) < eff_cap_r) && (PW'(widx_r) < eff_cap_r))
  `BRF_ASSERT_NEXT(a_rdata_held, clk, rst_n, s1_valid_r && !s1_move, $stable(mem_q_r))

endmodule

// ===== test/tb_byte_ring_fifo_with_skip_top.sv =====
// Self-checking testbench for byte_ring_fifo_with_skip_top: write, read, skip,
// flush and end-mark beats at several capacities, checked against a local predictor.
// Depends on brf_pkg and the RTL of byte_ring_fifo_with_skip_top.
`timescale 1ns / 1ps

module tb_byte_ring_fifo_with_skip_top;
  import brf_pkg::*;

  localparam int unsigned REQ_FIRST_UNUSED = 5;
  localparam int unsigned REQ_LAST_CODE    = 7;
  localparam int unsigned CNT_MAX          = 4096;
  localparam logic [CFG_AW-1:0] CAP_ADDR   = CFG_AW'({REG_CAPACITY, 2'b00});
  localparam int unsigned SETTLE_CYCLES    = 4;
  localparam int unsigned END_CYCLES       = 8;
  localparam int unsigned HOLD_CYCLES      = 150;
  localparam int unsigned HOLD_AT_A        = 330;
  localparam int unsigned HOLD_AT_B        = 1400;
  localparam int unsigned WATCHDOG_LIMIT   = 2000;
  localparam int unsigned LONG_FILL        = 500;

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [BYTE_W-1:0] data;
    logic [CNT_W-1:0]  cnt;
  } fifo_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rd_byte;
    logic [CNT_W-1:0]  moved;
    logic [CNT_W-1:0]  fill;
    logic              at_end;
    logic [TOT_W-1:0]  wr_total;
    logic [TOT_W-1:0]  rd_total;
  } fifo_res_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [REQ_W-1:0]    in_req_type = '0;
  logic [BYTE_W-1:0]   in_data_byte = '0;
  logic [CNT_W-1:0]    in_count = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [BYTE_W-1:0]   out_read_byte;
  logic [CNT_W-1:0]    out_moved;
  logic [CNT_W-1:0]    out_fill_level;
  logic                out_at_end;
  logic [TOT_W-1:0]    out_total_written;
  logic [TOT_W-1:0]    out_total_read;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CFG_AW-1:0]   paddr = '0;
  logic [CFG_DW-1:0]   pwdata = '0;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  // Predictor state: ring contents, indices, fill level, end mark, totals.
  logic [BYTE_W-1:0]   ring [DEPTH_DEFAULT];
  int unsigned         rd_idx, wr_idx, held;
  logic                end_mark;
  logic [TOT_W-1:0]    wr_total, rd_total;
  logic [CAP_W-1:0]    cap_reg = CAP_RESET;

  fifo_req_t           pend_q[$];
  fifo_res_t           result_q[$];

  int unsigned         items_queued, results_checked, random_items, cap_settings;
  int unsigned         dropped_writes, empty_reads, skip_beats, errors;
  int unsigned         in_gap, stall_left, hold_left, idle_cycles;
  bit                  in_fired, out_fired, in_burst, out_burst;

  byte_ring_fifo_with_skip_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_data_byte     (in_data_byte),
    .in_count         (in_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_byte    (out_read_byte),
    .out_moved        (out_moved),
    .out_fill_level   (out_fill_level),
    .out_at_end       (out_at_end),
    .out_total_written(out_total_written),
    .out_total_read   (out_total_read),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk = ~clk;

  // Capacity in effect: zero acts as one, anything above the built depth as the depth.
  function automatic int unsigned ring_limit();
    if (cap_reg == '0) return 1;
    if (cap_reg > DEPTH_DEFAULT) return DEPTH_DEFAULT;
    return int'(cap_reg);
  endfunction

  function automatic void clear_ring();
    rd_idx = 0;
    wr_idx = 0;
    held = 0;
    end_mark = 1'b0;
  endfunction

  // Applies one request beat to the predictor and returns the result it should give.
  function automatic fifo_res_t predict_beat(fifo_req_t r);
    fifo_res_t   e;
    int unsigned lim;
    int unsigned n;
    lim = ring_limit();
    e = '0;
    case (r.req)
      REQ_WRITE: begin
        if (held < lim) begin
          ring[wr_idx] = r.data;
          wr_idx = (wr_idx + 1) % lim;
          held++;
          wr_total++;
          e.moved = CNT_W'(1);
        end else begin
          dropped_writes++;
        end
      end
      REQ_READ: begin
        if (held > 0) begin
          e.rd_byte = ring[rd_idx];
          rd_idx = (rd_idx + 1) % lim;
          held--;
          rd_total++;
          e.moved = CNT_W'(1);
        end else begin
          empty_reads++;
        end
      end
      REQ_SKIP: begin
        n = (r.cnt < held) ? r.cnt : held;
        rd_idx = (rd_idx + n) % lim;
        held -= n;
        e.moved = CNT_W'(n);
        skip_beats++;
      end
      REQ_FLUSH: clear_ring();
      REQ_MARK_END: end_mark = 1'b1;
      default: ;
    endcase
    e.fill = CNT_W'(held);
    e.at_end = end_mark && (held == 0);
    e.wr_total = wr_total;
    e.rd_total = rd_total;
    return e;
  endfunction

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  // One random request; the rest of the percentage goes to skips and rare commands.
  function automatic fifo_req_t random_request(int unsigned wr_pct, int unsigned rd_pct,
                                               int unsigned lim);
    fifo_req_t   r;
    int unsigned pick;
    int unsigned sel;
    r.data = BYTE_W'($urandom);
    r.cnt = CNT_W'($urandom_range(0, 4));
    pick = $urandom_range(0, 99);
    if (pick < wr_pct) begin
      r.req = REQ_WRITE;
    end else if (pick < wr_pct + rd_pct) begin
      r.req = REQ_READ;
    end else if (pick < 92) begin
      r.req = REQ_SKIP;
      sel = $urandom_range(0, 9);
      if (sel < 5) r.cnt = CNT_W'($urandom_range(0, 4));
      else if (sel < 8) r.cnt = CNT_W'($urandom_range(0, (lim + 1 > CNT_MAX) ? CNT_MAX : lim + 1));
      else if (sel == 8) r.cnt = CNT_W'($urandom_range(0, CNT_MAX));
      else r.cnt = CNT_W'(CNT_MAX);
    end else if (pick < 95) begin
      r.req = REQ_FLUSH;
    end else if (pick < 98) begin
      r.req = REQ_MARK_END;
    end else begin
      r.req = REQ_W'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_CODE));
    end
    return r;
  endfunction

  task automatic push_req(fifo_req_t r);
    pend_q.push_back(r);
    items_queued++;
  endtask

  task automatic random_phase(int unsigned n, int unsigned wr_pct, int unsigned rd_pct);
    repeat (n) push_req(random_request(wr_pct, rd_pct, ring_limit()));
    random_items += n;
  endtask

  // Waits until every queued beat has produced its result, then lets the pipeline settle.
  task automatic drain();
    while (results_checked != items_queued) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes the capacity register while idle, updates the predictor, then reads it back.
  task automatic set_capacity(logic [CFG_DW-1:0] val);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAP_ADDR;
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    cap_reg = val[CAP_W-1:0];
    clear_ring();
    cap_settings++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field("capacity readback", 64'(cap_reg), 64'(prdata[CAP_W-1:0]));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Request driver: presents the next pending beat after the drawn gap.
  always @(negedge clk) begin : drive_requests
    fifo_req_t nxt;
    if (rst_n && (!in_valid || in_fired)) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (pend_q.size() != 0) begin
        nxt = pend_q.pop_front();
        in_req_type <= nxt.req;
        in_data_byte <= nxt.data;
        in_count <= nxt.cnt;
        in_valid <= 1'b1;
        in_gap = in_burst ? 0 : $urandom_range(0, 3);
        if ($urandom_range(0, 99) == 0) in_burst = !in_burst;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls per beat, plus two long hold-offs that back up the block.
  always @(negedge clk) begin : drive_ready
    if (rst_n) begin
      if (out_fired) begin
        if (results_checked == HOLD_AT_A || results_checked == HOLD_AT_B)
          hold_left = HOLD_CYCLES;
        stall_left = out_burst ? 0 : $urandom_range(0, 3);
        if ($urandom_range(0, 99) == 0) out_burst = !out_burst;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Each accepted request beat is predicted at once, in acceptance order.
  always @(posedge clk) begin : watch_requests
    in_fired = rst_n && in_valid && in_ready;
    if (in_fired)
      result_q.push_back(predict_beat(fifo_req_t'{in_req_type, in_data_byte, in_count}));
  end

  // Each accepted result beat is compared with the oldest prediction.
  always @(posedge clk) begin : watch_results
    fifo_res_t want;
    out_fired = rst_n && out_valid && out_ready;
    if (out_fired) begin
      if (result_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with no request pending, moved %0h fill %0h",
                 $time, out_moved, out_fill_level);
      end else begin
        want = result_q.pop_front();
        check_field("read_byte", 64'(want.rd_byte), 64'(out_read_byte));
        check_field("moved", 64'(want.moved), 64'(out_moved));
        check_field("fill_level", 64'(want.fill), 64'(out_fill_level));
        check_field("at_end", 64'(want.at_end), 64'(out_at_end));
        check_field("total_written", want.wr_total, out_total_written);
        check_field("total_read", want.rd_total, out_total_read);
      end
      results_checked++;
    end
  end

  // Watchdog: ends the run after too many cycles without any handshake.
  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel || !rst_n)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb_byte_ring_fifo_with_skip_top: done, errors");
      $finish;
    end
  end

  initial begin
    clear_ring();
    wr_total = '0;
    rd_total = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed beats at the reset capacity: empty ring, skips past the fill level,
    // end mark held across a write, unused codes, flush.
    push_req(fifo_req_t'{REQ_READ, 8'h00, 13'd0});
    push_req(fifo_req_t'{REQ_SKIP, 8'h00, 13'd0});
    push_req(fifo_req_t'{REQ_SKIP, 8'hFF, 13'd4096});
    push_req(fifo_req_t'{REQ_WRITE, 8'h00, 13'd0});
    push_req(fifo_req_t'{REQ_WRITE, 8'hFF, 13'h1FFF});
    push_req(fifo_req_t'{REQ_WRITE, 8'hA5, 13'd0});
    push_req(fifo_req_t'{REQ_READ, 8'h00, 13'd0});
    push_req(fifo_req_t'{REQ_SKIP, 8'h00, 13'd0});
    push_req(fifo_req_t'{REQ_SKIP, 8'h00, 13'd4096});
    push_req(fifo_req_t'{REQ_READ, 8'h00, 13'd0});
    push_req(fifo_req_t'{REQ_MARK_END, 8'h00, 13'd0});
    push_req(fifo_req_t'{REQ_WRITE, 8'h5A, 13'd0});
    push_req(fifo_req_t'{REQ_READ, 8'h00, 13'd0});
    push_req(fifo_req_t'{REQ_W'(REQ_FIRST_UNUSED), 8'h77, 13'd3});
    push_req(fifo_req_t'{REQ_W'(REQ_FIRST_UNUSED + 1), 8'h88, 13'd4096});
    push_req(fifo_req_t'{REQ_W'(REQ_LAST_CODE), 8'hFF, 13'd1});
    push_req(fifo_req_t'{REQ_FLUSH, 8'h00, 13'd0});
    push_req(fifo_req_t'{REQ_WRITE, 8'h3C, 13'd0});
    push_req(fifo_req_t'{REQ_FLUSH, 8'h00, 13'd0});

    // Capacity zero acts as one byte: second write is dropped, second read finds nothing.
    set_capacity(32'd0);
    push_req(fifo_req_t'{REQ_WRITE, 8'h11, 13'd0});
    push_req(fifo_req_t'{REQ_WRITE, 8'h22, 13'd0});
    push_req(fifo_req_t'{REQ_READ, 8'h00, 13'd0});
    push_req(fifo_req_t'{REQ_READ, 8'h00, 13'd0});
    push_req(fifo_req_t'{REQ_SKIP, 8'h00, 13'd4096});
    random_phase(100, 40, 40);

    set_capacity(32'd1);
    random_phase(100, 45, 35);
    set_capacity(32'd2);
    random_phase(100, 45, 35);
    set_capacity(32'd7);
    random_phase(200, 45, 35);
    set_capacity(CFG_DW'($urandom_range(3, 40)));
    random_phase(200, 50, 30);

    // Above the built depth acts as the depth: a long run of writes into a deep
    // ring, then one skip of most of it before mixed traffic.
    set_capacity(32'h1FFF);
    repeat (LONG_FILL) push_req(fifo_req_t'{REQ_WRITE, BYTE_W'($urandom), 13'd0});
    push_req(fifo_req_t'{REQ_SKIP, 8'h00, 13'd450});
    random_phase(150, 50, 35);

    // Full depth written with junk in the unused upper bits, skip-heavy traffic.
    set_capacity({CFG_DW'($urandom) >> CAP_W << CAP_W} | CFG_DW'(4096));
    random_phase(200, 40, 30);
    set_capacity(CFG_DW'($urandom_range(41, 300)));
    random_phase(250, 55, 30);

    drain();
    repeat (END_CYCLES) @(negedge clk);
    if (result_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, result_q.size());
    end
    $display("Ran %0d request beats (%0d random) over %0d capacity settings, %0d results checked.",
             items_queued, random_items, cap_settings, results_checked);
    $display("Writes dropped on a full ring: %0d, reads of an empty ring: %0d, skips: %0d.",
             dropped_writes, empty_reads, skip_beats);
    if (errors == 0)
      $display("tb_byte_ring_fifo_with_skip_top: done, clean");
    else
      $display("tb_byte_ring_fifo_with_skip_top: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/brf_pkg.sv
rtl/byte_ring_fifo_with_skip_top.sv
test/tb_byte_ring_fifo_with_skip_top.sv
